// ===== rtl/core/lfr_pkg.sv =====
package lfr_pkg;

  // list depth and the widths that follow from it
  localparam int unsigned NUM_FRAMES = 16;
  localparam int unsigned SLOT_W     = $clog2(NUM_FRAMES);
  localparam int unsigned COUNT_W    = $clog2(NUM_FRAMES + 1);

  // fixed field widths
  localparam int unsigned FRAME_W = 4;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned CMP_W   = (COUNT_W > CAP_W) ? COUNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_VICTIM = 2'd0,
    FUNC_PIN    = 2'd1,
    FUNC_UNPIN  = 2'd2
  } func_e;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic               pin;
    logic               ins;
    logic [FRAME_W-1:0] req_frame;
    logic [COUNT_W-1:0] count_next;
  } ctrl_t;

endpackage

// ===== rtl/core/lfr_req_if.sv =====
interface lfr_req_if;
  logic                       valid;
  logic                       ready;
  logic [lfr_pkg::FUNC_W-1:0]  func;
  logic [lfr_pkg::FRAME_W-1:0] frame;

  modport source (output valid, output func, output frame, input ready);
  modport sink (input valid, input func, input frame, output ready);
endinterface

// ===== rtl/core/lfr_rsp_if.sv =====
interface lfr_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [lfr_pkg::FRAME_W-1:0] victim_frame;
  logic                        dropped;
  logic [lfr_pkg::COUNT_W-1:0] count;

  modport source (output valid, output ok, output victim_frame, output dropped,
                  output count, input ready);
  modport sink (input valid, input ok, input victim_frame, input dropped,
                input count, output ready);
endinterface

// ===== rtl/core/lru_frame_replacer.sv =====
// channel   dir  handshake          payload
// req_i     in   valid/ready        func, frame
// rsp_o     out  valid/ready        ok, victim_frame, dropped, count
// cfg       in   cfg_we_i (no wait) cfg_wdata_i -> capacity
//
// one item per cycle while rsp_o takes results: the list lives in a chain of
// cells that all shift in the same cycle, so an operation completes in the cycle
// it is accepted; the result sits in an output register in the cycle after
// acceptance; req_i.ready stays high while that register is empty or being taken,
// so a stalled rsp_o holds back at most the next item
// reset clears every valid bit and the count, capacity returns to 16
module lru_frame_replacer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  lfr_req_if.sink                   req_i,
  lfr_rsp_if.source                 rsp_o,
  input  logic                      cfg_we_i,
  input  logic [lfr_pkg::CAP_W-1:0] cfg_wdata_i
);

  logic [lfr_pkg::CAP_W-1:0]   cap_q;
  logic [lfr_pkg::COUNT_W-1:0] count_q, count_d;

  // output register
  logic                        rsp_valid_q;
  logic                        ok_q, ok_d;
  logic [lfr_pkg::FRAME_W-1:0] victim_q, victim_d;
  logic                        drop_q, drop_d;
  logic [lfr_pkg::COUNT_W-1:0] rsp_count_q;

  logic                        accept;
  logic                        hit;
  logic [lfr_pkg::FRAME_W-1:0] tail_frame;
  lfr_pkg::ctrl_t              ctrl;
  lfr_pkg::func_e              func;

  // grown count and effective limit for an insert
  logic [lfr_pkg::COUNT_W-1:0] grown;
  logic [lfr_pkg::CMP_W-1:0]   limit;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign func        = lfr_pkg::func_e'(req_i.func);

  // a full list loses its tail by the shift itself
  assign grown = (count_q >= lfr_pkg::COUNT_W'(lfr_pkg::NUM_FRAMES)) ?
                 lfr_pkg::COUNT_W'(lfr_pkg::NUM_FRAMES) : count_q + 1'b1;

  // capacity above the list depth is clipped to the depth
  assign limit = (lfr_pkg::CMP_W'(cap_q) < lfr_pkg::CMP_W'(lfr_pkg::NUM_FRAMES)) ?
                 lfr_pkg::CMP_W'(cap_q) : lfr_pkg::CMP_W'(lfr_pkg::NUM_FRAMES);

  always_comb begin
    count_d        = count_q;
    ok_d           = 1'b0;
    victim_d       = '0;
    drop_d         = 1'b0;
    ctrl.pin       = 1'b0;
    ctrl.ins       = 1'b0;
    ctrl.req_frame = req_i.frame;
    if (accept) begin
      unique case (func)
        lfr_pkg::FUNC_VICTIM: begin
          if (count_q != '0) begin
            count_d  = count_q - 1'b1;
            ok_d     = 1'b1;
            victim_d = tail_frame;
          end
        end
        lfr_pkg::FUNC_PIN: begin
          if (hit) begin
            ctrl.pin = 1'b1;
            count_d  = count_q - 1'b1;
            ok_d     = 1'b1;
          end
        end
        lfr_pkg::FUNC_UNPIN: begin
          // already listed: nothing moves
          if (!hit) begin
            ctrl.ins = 1'b1;
            ok_d     = 1'b1;
            drop_d   = count_q >= lfr_pkg::COUNT_W'(lfr_pkg::NUM_FRAMES);
            if (lfr_pkg::CMP_W'(grown) > limit) begin
              count_d = lfr_pkg::COUNT_W'(limit);
              drop_d  = 1'b1;
            end else begin
              count_d = grown;
            end
          end
        end
        default: begin
          // unused code: no operation, count still reported
        end
      endcase
    end
    ctrl.count_next = count_d;
  end

  lfr_chain u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .hit_o       (hit),
    .tail_frame_o(tail_frame)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= lfr_pkg::CAP_RESET;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q     <= ok_d;
      victim_q <= victim_d;
      drop_q   <= drop_d;
    end
  end

  // count register already holds the post-operation value
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_count_q <= count_d;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.ok           = ok_q;
  assign rsp_o.victim_frame = victim_q;
  assign rsp_o.dropped      = drop_q;
  assign rsp_o.count        = rsp_count_q;

endmodule

// ===== rtl/core/lfr_cell.sv =====
module lfr_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lfr_pkg::ctrl_t              ctrl_i,
  input  logic [lfr_pkg::SLOT_W-1:0]  slot_i,
  input  logic [lfr_pkg::FRAME_W-1:0] left_frame_i,
  input  logic [lfr_pkg::FRAME_W-1:0] right_frame_i,
  input  logic                        hit_i,
  output logic                        hit_o,
  output logic [lfr_pkg::FRAME_W-1:0] frame_o,
  output logic                        valid_o
);

  logic [lfr_pkg::FRAME_W-1:0] frame_q, frame_d;
  logic                        valid_q, valid_d;

  // hit travels toward the tail: every cell at or past the match closes the gap
  assign hit_o = hit_i | (valid_q && (frame_q == ctrl_i.req_frame));

  always_comb begin
    frame_d = frame_q;
    if (ctrl_i.ins) begin
      frame_d = left_frame_i;
    end else if (ctrl_i.pin && hit_o) begin
      frame_d = right_frame_i;
    end
  end

  // occupied slots are always the lowest ones
  assign valid_d = lfr_pkg::COUNT_W'(slot_i) < ctrl_i.count_next;

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign frame_o = frame_q;
  assign valid_o = valid_q;

endmodule

// ===== rtl/core/lfr_chain.sv =====
module lfr_chain (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lfr_pkg::ctrl_t              ctrl_i,
  output logic                        hit_o,
  output logic [lfr_pkg::FRAME_W-1:0] tail_frame_o
);

  logic [lfr_pkg::FRAME_W-1:0] frame_w [lfr_pkg::NUM_FRAMES];
  logic                        valid_w [lfr_pkg::NUM_FRAMES+1];
  logic                        hit_w   [lfr_pkg::NUM_FRAMES+1];

  assign hit_w[0] = 1'b0;

  // past the last cell nothing is occupied
  assign valid_w[lfr_pkg::NUM_FRAMES] = 1'b0;

  for (genvar i = 0; i < lfr_pkg::NUM_FRAMES; i++) begin : g_cell
    logic [lfr_pkg::FRAME_W-1:0] left_w, right_w;

    if (i == 0) begin : g_head
      assign left_w = ctrl_i.req_frame;
    end else begin : g_mid_l
      assign left_w = frame_w[i-1];
    end

    if (i == lfr_pkg::NUM_FRAMES - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = frame_w[i+1];
    end

    lfr_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_i),
      .slot_i       (lfr_pkg::SLOT_W'(i)),
      .left_frame_i (left_w),
      .right_frame_i(right_w),
      .hit_i        (hit_w[i]),
      .hit_o        (hit_w[i+1]),
      .frame_o      (frame_w[i]),
      .valid_o      (valid_w[i])
    );
  end

  assign hit_o = hit_w[lfr_pkg::NUM_FRAMES];

  // tail is the last occupied cell; at most one cell qualifies
  always_comb begin
    tail_frame_o = '0;
    for (int i = 0; i < lfr_pkg::NUM_FRAMES; i++) begin
      if (valid_w[i] && !valid_w[i + 1]) begin
        tail_frame_o = tail_frame_o | frame_w[i];
      end
    end
  end

endmodule

// ===== sim/tb_lru_frame_replacer.sv =====
package lru_check_pkg;
  import lfr_pkg::*;

  typedef struct packed {
    logic               ok;
    logic [FRAME_W-1:0] victim_frame;
    logic               dropped;
    logic [COUNT_W-1:0] count;
  } rsp_item_t;

  // shadow copy of the recency list plus the results still owed by the block
  class lru_list_shadow;
    logic [FRAME_W-1:0] order [NUM_FRAMES];
    int                 listed;
    int unsigned        capacity;
    rsp_item_t          expected_rsp [$];
    int                 mismatches;
    int                 requests;
    int                 results;
    int                 victims;
    int                 drops;

    function new();
      listed     = 0;
      capacity   = CAP_RESET;
      mismatches = 0;
      requests   = 0;
      results    = 0;
      victims    = 0;
      drops      = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] cap);
      capacity = cap;
    endfunction

    function int find_frame(logic [FRAME_W-1:0] fr);
      int i;
      for (i = 0; i < listed; i++) begin
        if (order[i] == fr) return i;
      end
      return -1;
    endfunction

    // a frame that is listed right now (any frame if the list is empty), for pins that hit
    function logic [FRAME_W-1:0] pick_listed();
      if (listed == 0) return FRAME_W'($urandom_range(0, NUM_FRAMES - 1));
      return order[$urandom_range(0, listed - 1)];
    endfunction

    function void note_request(logic [FUNC_W-1:0] fn, logic [FRAME_W-1:0] fr);
      rsp_item_t want;
      int        pos;
      int        i;
      want = '0;
      pos  = find_frame(fr);
      requests++;
      case (fn)
        FUNC_VICTIM: begin
          if (listed > 0) begin
            want.victim_frame = order[listed - 1];
            want.ok           = 1'b1;
            listed--;
            victims++;
          end
        end
        FUNC_PIN: begin
          if (pos >= 0) begin
            for (i = pos; i < listed - 1; i++) order[i] = order[i + 1];
            listed--;
            want.ok = 1'b1;
          end
        end
        FUNC_UNPIN: begin
          if (pos < 0) begin
            if (listed >= NUM_FRAMES) begin
              listed       = NUM_FRAMES - 1;
              want.dropped = 1'b1;
            end
            for (i = listed; i > 0; i--) order[i] = order[i - 1];
            order[0] = fr;
            listed++;
            want.ok = 1'b1;
            while (listed > int'(capacity)) begin
              listed--;
              want.dropped = 1'b1;
            end
            if (want.dropped) drops++;
          end
        end
        default: begin
        end
      endcase
      want.count = COUNT_W'(listed);
      expected_rsp.push_back(want);
    endfunction

    function void report(string what, rsp_item_t want, rsp_item_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s: want ok=%0b victim=%0d dropped=%0b count=%0d, got ok=%0b victim=%0d dropped=%0b count=%0d",
                 $time, what, want.ok, want.victim_frame, want.dropped, want.count,
                 got.ok, got.victim_frame, got.dropped, got.count);
      end
    endfunction

    function void check_response(rsp_item_t got);
      rsp_item_t want;
      if (expected_rsp.size() == 0) begin
        report("result with nothing outstanding", '0, got);
        return;
      end
      want = expected_rsp.pop_front();
      results++;
      if (got.ok !== want.ok || got.victim_frame !== want.victim_frame ||
          got.dropped !== want.dropped || got.count !== want.count) begin
        report("result mismatch", want, got);
      end
    endfunction
  endclass

endpackage

module tb_lru_frame_replacer;
  timeunit 1ns;
  timeprecision 1ps;

  import lfr_pkg::*;
  import lru_check_pkg::*;

  // func code that the block must treat as a no-op
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int N_PHASES        = 10;
  localparam int ITEMS_PER_PHASE = 43;
  localparam int LONG_HOLD       = 150;   // cycles the receiver sits out once
  localparam int DRAIN_LIMIT     = 2000;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  lfr_req_if req_ch ();
  lfr_rsp_if rsp_ch ();

  lru_list_shadow tracker;

  // receiver hold-off request, raised by the stimulus and cleared by the receiver
  bit hold_rsp;
  int holds_done;
  int caps_written;
  int lost;

  lru_frame_replacer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the handshake locks up
  initial begin
    #2ms;
    $display("timeout with %0d results still outstanding", tracker.expected_rsp.size());
    $display("** lru_frame_replacer: FAILED **");
    $finish;
  end

  // sample both channels on the clock edge; results first, since a result
  // at this edge always belongs to an item accepted at an earlier one
  always @(posedge clk_i) begin : watch_channels
    rsp_item_t seen;
    if (rst_ni) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        seen.ok           = rsp_ch.ok;
        seen.victim_frame = rsp_ch.victim_frame;
        seen.dropped      = rsp_ch.dropped;
        seen.count        = rsp_ch.count;
        tracker.check_response(seen);
      end
      if (req_ch.valid && req_ch.ready) begin
        tracker.note_request(req_ch.func, req_ch.frame);
      end
    end
  end

  // receiver pacing: runs of always-ready, mostly-ready, a fixed two-in-three
  // pattern and mostly-stalled, plus one long hold-off on request
  initial begin : rsp_pacing
    int mode;
    int len;
    int k;
    int tick;
    rsp_ch.ready <= 1'b0;
    tick = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_rsp = 1'b0;
        holds_done++;
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(4, 48);
        for (k = 0; k < len && !hold_rsp; k++) begin
          case (mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_ch.ready <= (tick % 3 != 0);
            default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          endcase
          tick++;
          @(posedge clk_i);
        end
      end
    end
  end

  // offer one item and hold it until the block takes it; valid stays high
  // so that back-to-back calls form a burst
  task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [FRAME_W-1:0] fr);
    req_ch.valid <= 1'b1;
    req_ch.func  <= fn;
    req_ch.frame <= fr;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // mostly unpins and pins of listed frames so the list stays busy,
  // with victims draining it and the odd unused code
  task automatic send_random_item();
    logic [FUNC_W-1:0]  fn;
    logic [FRAME_W-1:0] fr;
    int                 r;
    r = $urandom_range(0, 99);
    if (r < 45)      fn = FUNC_UNPIN;
    else if (r < 72) fn = FUNC_PIN;
    else if (r < 96) fn = FUNC_VICTIM;
    else             fn = FUNC_UNUSED;
    if (fn == FUNC_PIN && $urandom_range(0, 3) != 0) fr = tracker.pick_listed();
    else fr = FRAME_W'($urandom_range(0, NUM_FRAMES - 1));
    send_item(fn, fr);
  endtask

  // stop offering and wait for every owed result; the first edge lets the
  // watcher note an item taken at the edge we returned on
  task automatic drain();
    int waited;
    req_ch.valid <= 1'b0;
    waited = 0;
    @(posedge clk_i);
    while (tracker.expected_rsp.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (tracker.expected_rsp.size() != 0) begin
      lost += tracker.expected_rsp.size();
      $display("%0t: %0d results never arrived", $time, tracker.expected_rsp.size());
      tracker.expected_rsp.delete();
    end
    @(posedge clk_i);
  endtask

  // only called with the block idle
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    tracker.set_capacity(cap);
    caps_written++;
  endtask

  initial begin : stimulus
    logic [CAP_W-1:0] phase_cap [N_PHASES];
    int               p;
    int               k;
    int               burst_left;
    bit               gaps_on;

    phase_cap = '{5'd16, 5'd1, 5'd31, 5'd4, 5'd0, 5'd17, 5'd8, 5'd15, 5'd2, 5'd16};
    tracker      = new();
    hold_rsp     = 1'b0;
    holds_done   = 0;
    caps_written = 0;
    lost         = 0;

    rst_ni       <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    req_ch.valid <= 1'b0;
    req_ch.func  <= FUNC_VICTIM;
    req_ch.frame <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset capacity, empty-list victim, pin miss, unused code,
    // repeated unpin, pin hit and a victim that empties the list again
    send_item(FUNC_VICTIM, 4'd0);
    send_item(FUNC_PIN, 4'd0);
    send_item(FUNC_UNUSED, 4'd15);
    send_item(FUNC_UNPIN, 4'd0);
    send_item(FUNC_UNPIN, 4'd15);
    send_item(FUNC_UNPIN, 4'd15);
    send_item(FUNC_PIN, 4'd15);
    send_item(FUNC_VICTIM, 4'd15);
    drain();

    // capacity zero: the new frame goes in and straight back out
    write_capacity(5'd0);
    send_item(FUNC_UNPIN, 4'd9);
    drain();

    // capacity above the list depth, then a pin from the middle of the list
    write_capacity(5'd31);
    send_item(FUNC_UNPIN, 4'd1);
    send_item(FUNC_UNPIN, 4'd2);
    send_item(FUNC_UNPIN, 4'd3);
    send_item(FUNC_UNPIN, 4'd4);
    send_item(FUNC_UNPIN, 4'd5);
    send_item(FUNC_PIN, 4'd3);
    drain();

    // capacity lowered under a list of four entries: one insert drops several entries
    write_capacity(5'd2);
    send_item(FUNC_UNPIN, 4'd10);
    send_item(FUNC_VICTIM, 4'd0);
    send_item(FUNC_VICTIM, 4'd0);
    send_item(FUNC_VICTIM, 4'd0);
    drain();

    // random phases, one capacity each; every third phase runs without gaps
    for (p = 0; p < N_PHASES; p++) begin
      write_capacity((p == 7) ? CAP_W'($urandom_range(0, 31)) : phase_cap[p]);
      gaps_on    = (p % 3) != 2;
      burst_left = $urandom_range(1, 16);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        // long receiver stall while the sender keeps pushing
        if (p == 2 && k == 5) hold_rsp = 1'b1;
        send_random_item();
        if (gaps_on) begin
          burst_left--;
          if (burst_left == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk_i);
            burst_left = $urandom_range(1, 16);
          end
        end
      end
      drain();
    end

    repeat (4) @(posedge clk_i);
    $display("run covered %0d requests and %0d results: %0d victims taken, %0d inserts with drops",
             tracker.requests, tracker.results, tracker.victims, tracker.drops);
    $display("%0d capacity writes, %0d long receiver hold-offs, %0d mismatches",
             caps_written, holds_done, tracker.mismatches);
    if (tracker.mismatches == 0 && lost == 0 && tracker.expected_rsp.size() == 0) begin
      $display("** lru_frame_replacer: PASSED **");
    end else begin
      $display("** lru_frame_replacer: FAILED **");
    end
    $finish;
  end

endmodule

// ===== lru_frame_replacer.f =====
rtl/core/lfr_pkg.sv
rtl/core/lfr_req_if.sv
rtl/core/lfr_rsp_if.sv
rtl/core/lfr_cell.sv
rtl/core/lfr_chain.sv
rtl/core/lru_frame_replacer.sv
sim/tb_lru_frame_replacer.sv
